// ===== rtl/kbr_pkg.sv =====
// ----------------------------------------------------------------------------
// kbr_pkg
// Shared types, constants and the key translation function of the keyboard
// buffer with typematic repeat.
// ----------------------------------------------------------------------------
package kbr_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] FUNC_KEY_DOWN = 3'd0;
   localparam logic [2:0] FUNC_KEY_UP   = 3'd1;
   localparam logic [2:0] FUNC_TICK     = 3'd2;
   localparam logic [2:0] FUNC_GET_KEY  = 3'd3;
   localparam logic [2:0] FUNC_CHECK    = 3'd4;

   localparam logic CSR_REPEAT_DELAY    = 1'b0;
   localparam logic CSR_REPEAT_INTERVAL = 1'b1;

   localparam logic [15:0] REPEAT_DELAY_RESET    = 16'd400;
   localparam logic [15:0] REPEAT_INTERVAL_RESET = 16'd50;

   typedef struct packed {
      logic [2:0]  func;
      logic [30:0] key_sym;
      logic        shift_down;
      logic        ctrl_down;
      logic        alt_down;
      logic        is_repeat;
   } req_type;

   typedef struct packed {
      logic [15:0] key_word;
      logic        no_key;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] word;
   } push_type;

   typedef struct packed {
      logic        empty;
      logic [15:0] head;
   } fifo_status_type;

   function automatic logic [7:0] letter_scan(logic [4:0] idx);
      case (idx)
         5'd0:  return 8'h1E;
         5'd1:  return 8'h30;
         5'd2:  return 8'h2E;
         5'd3:  return 8'h20;
         5'd4:  return 8'h12;
         5'd5:  return 8'h21;
         5'd6:  return 8'h22;
         5'd7:  return 8'h23;
         5'd8:  return 8'h17;
         5'd9:  return 8'h24;
         5'd10: return 8'h25;
         5'd11: return 8'h26;
         5'd12: return 8'h32;
         5'd13: return 8'h31;
         5'd14: return 8'h18;
         5'd15: return 8'h19;
         5'd16: return 8'h10;
         5'd17: return 8'h13;
         5'd18: return 8'h1F;
         5'd19: return 8'h14;
         5'd20: return 8'h16;
         5'd21: return 8'h2F;
         5'd22: return 8'h11;
         5'd23: return 8'h2D;
         5'd24: return 8'h15;
         5'd25: return 8'h2C;
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] digit_shifted(logic [3:0] d);
      case (d)
         4'd0: return 8'h29;
         4'd1: return 8'h21;
         4'd2: return 8'h40;
         4'd3: return 8'h23;
         4'd4: return 8'h24;
         4'd5: return 8'h25;
         4'd6: return 8'h5E;
         4'd7: return 8'h26;
         4'd8: return 8'h2A;
         4'd9: return 8'h28;
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [15:0] punct_word(logic [7:0] c, logic sh);
      case (c)
         8'h20: return 16'h3920;
         8'h2D: return {8'h0C, sh ? 8'h5F : 8'h2D};
         8'h3D: return {8'h0D, sh ? 8'h2B : 8'h3D};
         8'h5B: return {8'h1A, sh ? 8'h7B : 8'h5B};
         8'h5D: return {8'h1B, sh ? 8'h7D : 8'h5D};
         8'h5C: return {8'h2B, sh ? 8'h7C : 8'h5C};
         8'h3B: return {8'h27, sh ? 8'h3A : 8'h3B};
         8'h27: return {8'h28, sh ? 8'h22 : 8'h27};
         8'h60: return {8'h29, sh ? 8'h7E : 8'h60};
         8'h2C: return {8'h33, sh ? 8'h3C : 8'h2C};
         8'h2E: return {8'h34, sh ? 8'h3E : 8'h2E};
         8'h2F: return {8'h35, sh ? 8'h3F : 8'h2F};
         default: return 16'h0000;
      endcase
   endfunction

   // Host keycode plus modifiers to a scan code (high byte) and ASCII (low byte).
   function automatic logic [15:0] translate(logic [30:0] sym, logic sh, logic ct,
                                             logic al);
      logic        plain;
      logic        ext;
      logic        letter;
      logic        digit;
      logic [7:0]  c;
      logic [7:0]  idx;
      logic [3:0]  d;
      logic [15:0] w;
      plain  = (sym[30:8] == 23'd0);
      ext    = (sym[30:8] == 23'h40_0000);
      c      = sym[7:0];
      letter = plain && (c >= 8'h61) && (c <= 8'h7A);
      digit  = plain && (c >= 8'h30) && (c <= 8'h39);
      idx    = c - 8'h61;
      d      = 4'(c - 8'h30);
      w      = 16'h0000;
      if (plain && (c >= 8'h20) && (c <= 8'h7A) && !ct && !al) begin
         if (letter) begin
            w = {letter_scan(idx[4:0]), sh ? (c - 8'h20) : c};
         end else if (digit) begin
            w = {(d == 4'd0) ? 8'h0B : (8'h01 + {4'd0, d}), sh ? digit_shifted(d) : c};
         end else begin
            w = punct_word(c, sh);
         end
      end
      if (w == 16'h0000) begin
         if (plain) begin
            case (c)
               8'd13:   w = 16'h1C0D;
               8'd27:   w = 16'h011B;
               8'd8:    w = 16'h0E08;
               8'd9:    w = 16'h0F09;
               8'd127:  w = ct ? 16'h9300 : 16'h5300;
               default: w = 16'h0000;
            endcase
         end else if (ext) begin
            case (c)
               8'd73:   w = 16'h5200;
               8'd74:   w = ct ? 16'h7700 : 16'h4700;
               8'd77:   w = ct ? 16'h7500 : 16'h4F00;
               8'd75:   w = al ? 16'h9900 : 16'h4900;
               8'd78:   w = al ? 16'hA100 : 16'h5100;
               8'd82:   w = ct ? 16'h8D00 : (al ? 16'h9800 : 16'h4800);
               8'd81:   w = ct ? 16'h9100 : (al ? 16'hA000 : 16'h5000);
               8'd80:   w = ct ? 16'h7300 : (al ? 16'h9B00 : 16'h4B00);
               8'd79:   w = ct ? 16'h7400 : (al ? 16'h9D00 : 16'h4D00);
               8'd58:   w = 16'h3B00;
               8'd59:   w = 16'h3C00;
               8'd60:   w = 16'h3D00;
               8'd61:   w = 16'h3E00;
               8'd62:   w = 16'h3F00;
               8'd63:   w = 16'h4000;
               8'd64:   w = 16'h4100;
               8'd65:   w = 16'h4200;
               8'd66:   w = 16'h4300;
               8'd67:   w = 16'h4400;
               8'd68:   w = 16'h8500;
               8'd69:   w = 16'h8600;
               default: w = 16'h0000;
            endcase
         end
      end
      if (w == 16'h0000) begin
         if (ct && letter) begin
            w = {letter_scan(idx[4:0]), idx + 8'h01};
         end else if (al && letter) begin
            w = {letter_scan(idx[4:0]), 8'h00};
         end else if (al && plain && (c == 8'h60)) begin
            w = 16'h2900;
         end
      end
      return w;
   endfunction

endpackage

// ===== rtl/kbr_fifo.sv =====
// ----------------------------------------------------------------------------
// kbr_fifo
// Key word queue: a memory with wrap-around pointers and a fill count. The
// word at the read pointer is kept in a registered head, so a pop delivers
// it at once. Pushes into a full queue are dropped.
// ----------------------------------------------------------------------------
module kbr_fifo
   import kbr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  push_type        push,
   input  logic            pop,
   output fifo_status_type status
);

   logic [15:0]      fifo_mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      head_ff;
   logic             do_push;

   assign do_push = push.valid && (count_ff != CNT_W'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end else if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         fifo_mem_ff[wr_ptr_ff] <= push.word;
      end
   end

   // A word written where the next head is read bypasses the memory.
   always_ff @(posedge clock) begin
      if (do_push && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= push.word;
      end else begin
         head_ff <= fifo_mem_ff[rd_ptr_in];
      end
   end

   assign status.empty = (count_ff == '0);
   assign status.head  = head_ff;

endmodule

// ===== rtl/kbr_typematic.sv =====
// ----------------------------------------------------------------------------
// kbr_typematic
// Key translation, held key tracking and typematic repeat countdown, with the
// repeat delay and interval registers. Produces at most one push per item.
// ----------------------------------------------------------------------------
module kbr_typematic
   import kbr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  req_type     item,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   output push_type    push
);

   logic [30:0] held_sym_ff, held_sym_in;
   logic [15:0] held_word_ff, held_word_in;
   logic [15:0] countdown_ff, countdown_in;
   logic [15:0] delay_ff;
   logic [15:0] interval_ff;
   logic [15:0] word;

   assign word = translate(item.key_sym, item.shift_down, item.ctrl_down, item.alt_down);

   always_comb begin
      held_sym_in  = held_sym_ff;
      held_word_in = held_word_ff;
      countdown_in = countdown_ff;
      push.valid   = 1'b0;
      push.word    = word;
      if (step) begin
         case (item.func)
            FUNC_KEY_DOWN: begin
               if (!item.is_repeat && (word != 16'h0000)) begin
                  push.valid   = 1'b1;
                  held_sym_in  = item.key_sym;
                  held_word_in = word;
                  countdown_in = delay_ff;
               end
            end
            FUNC_KEY_UP: begin
               if (item.key_sym == held_sym_ff) begin
                  held_sym_in  = '0;
                  held_word_in = '0;
               end
            end
            FUNC_TICK: begin
               if (held_word_ff != 16'h0000) begin
                  if (countdown_ff <= 16'd1) begin
                     push.valid   = 1'b1;
                     push.word    = held_word_ff;
                     countdown_in = interval_ff;
                  end else begin
                     countdown_in = countdown_ff - 16'd1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_sym_ff  <= '0;
         held_word_ff <= '0;
         countdown_ff <= '0;
         delay_ff     <= REPEAT_DELAY_RESET;
         interval_ff  <= REPEAT_INTERVAL_RESET;
      end else begin
         held_sym_ff  <= held_sym_in;
         held_word_ff <= held_word_in;
         countdown_ff <= countdown_in;
         if (csr_we && (csr_index == CSR_REPEAT_DELAY)) begin
            delay_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == CSR_REPEAT_INTERVAL)) begin
            interval_ff <= csr_wdata;
         end
      end
   end

endmodule

// ===== rtl/keyboard_buffer_with_repeat_unit.sv =====
// ----------------------------------------------------------------------------
// keyboard_buffer_with_repeat_unit
// Keyboard event buffer with typematic repeat and a 64-word key queue.
// ----------------------------------------------------------------------------
// An event is taken into an input register and handled from there in a single
// pass through the translation, repeat and queue logic, so the block takes one
// event per cycle unless a get key or check waits on an unready response; get
// key and check give one word each through an output register, other events
// give none. The rate rests on that pass and on the registered queue head,
// so a pop delivers at once. The queue memory needs no clearing after reset.
module keyboard_buffer_with_repeat_unit
   import kbr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   req_type         in_ff;
   logic            in_valid_ff, in_valid_in;
   rsp_type         rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            has_rsp;
   logic            step;
   logic            pop;
   push_type        push;
   fifo_status_type fifo_status;

   assign has_rsp   = (in_ff.func == FUNC_GET_KEY) || (in_ff.func == FUNC_CHECK);
   assign step      = in_valid_ff && (!has_rsp || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign pop       = step && (in_ff.func == FUNC_GET_KEY) && !fifo_status.empty;

   kbr_typematic u_typematic (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (in_ff),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .push      (push)
   );

   kbr_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .status (fifo_status)
   );

   always_comb begin
      in_valid_in     = in_valid_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_in          = rsp_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (step) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end
      if (step && has_rsp) begin
         rsp_valid_in    = 1'b1;
         rsp_in.no_key   = fifo_status.empty;
         rsp_in.key_word = pop ? fifo_status.head : 16'h0000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
